### rtl/core/ghrc_pkg.sv
// Package: types and constants shared by the guest/host register cache.
`timescale 1ns / 1ps
package ghrc_pkg;

  localparam int unsigned OpW = 3;
  localparam int unsigned KindW = 3;
  localparam int unsigned ActW = 2;
  localparam int unsigned TypeW = 3;
  localparam int unsigned GIdxW = 5;
  localparam int unsigned HIdxW = 4;
  localparam int unsigned MaskW = 16;
  localparam logic [MaskW-1:0] MaskReset = 16'hF00F;

  localparam logic [OpW-1:0] OpMap = 3'd0;
  localparam logic [OpW-1:0] OpMark = 3'd1;
  localparam logic [OpW-1:0] OpUnlock = 3'd2;
  localparam logic [OpW-1:0] OpClearJump = 3'd3;
  localparam logic [OpW-1:0] OpClearBranch = 3'd4;
  localparam logic [OpW-1:0] OpReset = 3'd5;

  localparam logic [ActW-1:0] ActPlain = 2'd0;
  localparam logic [ActW-1:0] ActLoad = 2'd1;
  localparam logic [ActW-1:0] ActBranch = 2'd2;

  localparam logic [KindW-1:0] KindHost = 3'd0;
  localparam logic [KindW-1:0] KindSpill = 3'd1;
  localparam logic [KindW-1:0] KindLoad = 3'd2;
  localparam logic [KindW-1:0] KindZero = 3'd3;
  localparam logic [KindW-1:0] KindDone = 3'd4;
  localparam logic [KindW-1:0] KindNoFree = 3'd5;

  localparam logic [TypeW-1:0] TypeEmpty = 3'd0;
  localparam logic [TypeW-1:0] TypeReserved = 3'd1;

  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [GIdxW-1:0] guest_reg;
    logic [HIdxW-1:0] host_reg;
    logic [ActW-1:0]  action;
    logic [TypeW-1:0] host_type;
  } req_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [HIdxW-1:0] host_index;
    logic [GIdxW-1:0] guest_index;
    logic             last;
  } rsp_t;

endpackage

### rtl/core/guest_host_register_cache.sv
// Top level: guest-to-host register cache with a sequencer over the state tables.
// One operation is taken at a time; inputs are stalled until its last result has been
// handed to the output register. The sequencer walks the tables one entry per cycle,
// holding an entry while a result for it cannot enter the full, stalled output register.
// Spill and load results leave in the scan step that finds them.
`timescale 1ns / 1ps
module guest_host_register_cache #(
  parameter int unsigned GUEST_REGS = 32,
  parameter int unsigned HOST_REGS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid,
  output logic           in_stall,
  input  ghrc_pkg::req_t in_data_i,
  output logic           out_valid,
  input  logic           out_stall,
  output ghrc_pkg::rsp_t out_data_o,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [ghrc_pkg::MaskW-1:0] cfg_data_i
);
  localparam int unsigned GW = (GUEST_REGS > 1) ? $clog2(GUEST_REGS) : 1;
  localparam int unsigned HW = (HOST_REGS > 1) ? $clog2(HOST_REGS) : 1;
  localparam int unsigned GC = $clog2(GUEST_REGS + 1);
  localparam int unsigned HC = $clog2(HOST_REGS + 1);

  typedef enum logic [7:0] {
    StIdle   = 8'b00000001,
    StGuests = 8'b00000010,
    StHosts  = 8'b00000100,
    StScan   = 8'b00001000,
    StFree   = 8'b00010000,
    StAlloc  = 8'b00100000,
    StFinal  = 8'b01000000,
    StEmit   = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic [ghrc_pkg::MaskW-1:0] mask_q;
  logic [GUEST_REGS-1:0] gm_q, gd_q;
  logic [HW-1:0] g2h_q [GUEST_REGS];
  logic [ghrc_pkg::TypeW-1:0] hk_q [HOST_REGS];
  logic [HOST_REGS-1:0] hm_q, hb_q, hl_q;
  logic [GW-1:0] h2g_q [HOST_REGS];
  logic [HW-1:0] fo_q [HOST_REGS];
  logic [HC-1:0] ftot_q, cur_q;
  logic [GC-1:0] gi_q;
  logic [HC-1:0] hi_q;
  logic found_q;
  ghrc_pkg::req_t req_q;
  logic [GW-1:0] g_q;
  ghrc_pkg::rsp_t pend_q;
  state_e ret_q;

  logic push, full;
  ghrc_pkg::rsp_t push_data;

  ghrc_out_reg u_out (
    .clk_i, .rst_ni, .push_i(push), .data_i(push_data), .full_o(full),
    .valid_o(out_valid), .stall_i(out_stall), .data_o(out_data_o)
  );

  assign in_stall = (state_q != StIdle);
  assign cfg_ready = (state_q == StIdle);
  wire can_push = !full || !out_stall;

  function automatic ghrc_pkg::rsp_t mk(logic [ghrc_pkg::KindW-1:0] k, logic [HW-1:0] h,
                                        logic [GW-1:0] g, logic l);
    ghrc_pkg::rsp_t r;
    r.kind = k;
    r.host_index = ghrc_pkg::HIdxW'(h);
    r.guest_index = ghrc_pkg::GIdxW'(g);
    r.last = l;
    return r;
  endfunction

  function automatic logic [GW-1:0] gmod(logic [ghrc_pkg::GIdxW-1:0] v);
    logic [11:0] r;
    r = 12'(v);
    for (int s = 4; s >= 0; s--) begin
      if (r >= 12'(GUEST_REGS << s)) r = r - 12'(GUEST_REGS << s);
    end
    return GW'(r);
  endfunction

  wire [GW-1:0] gsel = gi_q[GW-1:0];
  wire [HW-1:0] hsel = hi_q[HW-1:0];
  wire [HW-1:0] gh = g2h_q[g_q];
  wire [HW-1:0] ch = fo_q[cur_q[HW-1:0]];
  wire [HW-1:0] fh = fo_q[hsel];
  wire [GW-1:0] fg = h2g_q[fh];
  wire [ghrc_pkg::ActW-1:0] act =
    (req_q.action == 2'd3) ? ghrc_pkg::ActPlain : req_q.action;
  wire hres = (32'(hi_q) < ghrc_pkg::MaskW) && mask_q[hi_q[HW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StHosts;
      mask_q <= ghrc_pkg::MaskReset;
      gm_q <= '0; gd_q <= '0; hm_q <= '0; hb_q <= '0; hl_q <= '0;
      ftot_q <= '0; cur_q <= '0; gi_q <= '0; hi_q <= '0; found_q <= 1'b0;
      ret_q <= StIdle;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (cfg_valid) mask_q <= cfg_data_i;
          if (in_valid) begin
            req_q <= in_data_i;
            g_q <= gmod(in_data_i.guest_reg);
            gi_q <= '0; hi_q <= '0;
            unique case (in_data_i.operation)
              ghrc_pkg::OpMap: state_q <= StScan;
              ghrc_pkg::OpMark: begin
                gd_q[gmod(in_data_i.guest_reg)] <= 1'b1;
                state_q <= StFinal;
              end
              ghrc_pkg::OpUnlock: begin
                if (32'(in_data_i.host_reg) < HOST_REGS) begin
                  hl_q[HW'(in_data_i.host_reg)] <= 1'b0;
                  hb_q[HW'(in_data_i.host_reg)] <= 1'b0;
                end
                state_q <= StFinal;
              end
              ghrc_pkg::OpClearJump, ghrc_pkg::OpClearBranch: state_q <= StGuests;
              ghrc_pkg::OpReset: begin
                ftot_q <= '0; cur_q <= '0; state_q <= StHosts; ret_q <= StFinal;
              end
              default: state_q <= StFinal;
            endcase
          end
        end
        StHosts: begin
          if (hi_q == HC'(HOST_REGS)) begin
            gm_q <= '0; gd_q <= '0;
            for (int i = 0; i < GUEST_REGS; i++) g2h_q[i] <= '0;
            state_q <= (ret_q == StIdle) ? StIdle : StFinal;
          end else begin
            hk_q[hsel] <= hres ? ghrc_pkg::TypeReserved : ghrc_pkg::TypeEmpty;
            hm_q[hsel] <= 1'b0; h2g_q[hsel] <= '0; hb_q[hsel] <= 1'b0; hl_q[hsel] <= 1'b0;
            if (!hres) begin
              fo_q[ftot_q[HW-1:0]] <= hsel;
              ftot_q <= ftot_q + 1'b1;
            end
            hi_q <= hi_q + 1'b1;
          end
        end
        StGuests: begin
          if (gi_q == GC'(GUEST_REGS)) begin
            state_q <= StFinal;
          end else if (gm_q[gsel] && gd_q[gsel] && gi_q != '0 && !can_push) begin
          end else begin
            if (req_q.operation == ghrc_pkg::OpClearJump && gm_q[gsel]) begin
              gd_q[gsel] <= 1'b0; gm_q[gsel] <= 1'b0; g2h_q[gsel] <= '0;
              hm_q[g2h_q[gsel]] <= 1'b0; h2g_q[g2h_q[gsel]] <= '0;
              hk_q[g2h_q[gsel]] <= ghrc_pkg::TypeEmpty; hl_q[g2h_q[gsel]] <= 1'b0;
            end
            gi_q <= gi_q + 1'b1;
          end
        end
        StScan: begin
          if (gm_q[g_q]) begin
            if (act != ghrc_pkg::ActBranch) begin
              hl_q[gh] <= 1'b1;
              pend_q <= mk(ghrc_pkg::KindHost, gh, g_q, 1'b1);
              state_q <= StEmit; ret_q <= StIdle;
            end else if (!(g_q != '0 && gd_q[g_q]) || can_push) begin
              gd_q[g_q] <= 1'b0; gm_q[g_q] <= 1'b0; g2h_q[g_q] <= '0;
              hk_q[gh] <= req_q.host_type; hm_q[gh] <= 1'b0; h2g_q[gh] <= '0;
              hl_q[gh] <= 1'b1; hb_q[gh] <= 1'b1;
              pend_q <= mk(ghrc_pkg::KindHost, gh, g_q, 1'b1);
              state_q <= StEmit; ret_q <= StIdle;
            end
          end else if (cur_q < ftot_q && hk_q[ch] != ghrc_pkg::TypeEmpty) begin
            cur_q <= cur_q + 1'b1;
          end else if (cur_q >= ftot_q) begin
            hi_q <= '0; found_q <= 1'b0; state_q <= StFree;
          end else begin
            state_q <= StAlloc;
          end
        end
        StFree: begin
          if (hi_q >= ftot_q) begin
            if (found_q) begin
              state_q <= StAlloc;
            end else begin
              pend_q <= mk(ghrc_pkg::KindNoFree, '0, g_q, 1'b1);
              state_q <= StEmit; ret_q <= StIdle;
            end
          end else if (!hl_q[fh]) begin
            if (!(hm_q[fh] && gm_q[fg] && g2h_q[fg] == fh && fg != '0 && gd_q[fg])
                || can_push) begin
              if (hm_q[fh] && gm_q[fg] && g2h_q[fg] == fh) begin
                gd_q[fg] <= 1'b0; gm_q[fg] <= 1'b0; g2h_q[fg] <= '0;
              end
              hm_q[fh] <= 1'b0; h2g_q[fh] <= '0;
              hk_q[fh] <= ghrc_pkg::TypeEmpty; hl_q[fh] <= 1'b0;
              if (!found_q) begin
                cur_q <= hi_q; found_q <= 1'b1;
              end
              hi_q <= hi_q + 1'b1;
            end
          end else begin
            hi_q <= hi_q + 1'b1;
          end
        end
        StAlloc: begin
          if (act == ghrc_pkg::ActPlain || can_push) begin
            hk_q[ch] <= req_q.host_type; hl_q[ch] <= 1'b1; gd_q[g_q] <= 1'b0;
            if (act != ghrc_pkg::ActBranch) begin
              hm_q[ch] <= 1'b1; h2g_q[ch] <= g_q; gm_q[g_q] <= 1'b1; g2h_q[g_q] <= ch;
            end else begin
              hm_q[ch] <= 1'b0; h2g_q[ch] <= '0; hb_q[ch] <= 1'b1;
            end
            cur_q <= cur_q + 1'b1;
            pend_q <= mk(ghrc_pkg::KindHost, ch, g_q, 1'b1);
            state_q <= StEmit; ret_q <= StIdle;
          end
        end
        StFinal: begin
          pend_q <= mk(ghrc_pkg::KindDone, '0, '0, 1'b1);
          state_q <= StEmit; ret_q <= StIdle;
        end
        StEmit: begin
          if (can_push) state_q <= ret_q;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_comb begin
    push = 1'b0;
    push_data = pend_q;
    unique case (state_q)
      StGuests: begin
        push = (gi_q != GC'(GUEST_REGS)) && gm_q[gsel] && gd_q[gsel] && gi_q != '0
               && can_push;
        push_data = mk(ghrc_pkg::KindSpill, g2h_q[gsel], gsel, 1'b0);
      end
      StScan: begin
        push = gm_q[g_q] && act == ghrc_pkg::ActBranch && g_q != '0 && gd_q[g_q]
               && can_push;
        push_data = mk(ghrc_pkg::KindSpill, gh, g_q, 1'b0);
      end
      StFree: begin
        push = (hi_q < ftot_q) && !hl_q[fh] && hm_q[fh] && gm_q[fg] && g2h_q[fg] == fh
               && fg != '0 && gd_q[fg] && can_push;
        push_data = mk(ghrc_pkg::KindSpill, fh, fg, 1'b0);
      end
      StAlloc: begin
        push = act != ghrc_pkg::ActPlain && can_push;
        push_data = mk((g_q != '0) ? ghrc_pkg::KindLoad : ghrc_pkg::KindZero, ch, g_q,
                       1'b0);
      end
      StEmit: push = can_push;
      default: push = 1'b0;
    endcase
  end
endmodule

### rtl/core/ghrc_out_reg.sv
// Output register: holds one result transfer until the consumer takes it.
`timescale 1ns / 1ps
module ghrc_out_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ghrc_pkg::rsp_t  data_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            stall_i,
  output ghrc_pkg::rsp_t  data_o
);
  logic full_q, full_d;
  ghrc_pkg::rsp_t data_q;

  always_comb begin
    full_d = full_q;
    if (full_q && !stall_i) full_d = 1'b0;
    if (push_i) full_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) data_q <= data_i;
  end

  assign full_o = full_q;
  assign valid_o = full_q;
  assign data_o = data_q;
endmodule

### rtl/core/ghrc_checker.sv
// Checker: port-level properties of the register cache, bound to the top level.
`timescale 1ns / 1ps
module ghrc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input ghrc_pkg::rsp_t out_data_o,
  input logic           cfg_ready
);
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(out_data_o))
    else $error("output changed while stalled");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted while busy");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready == !in_stall)
    else $error("config port open while busy");
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data_o.kind <= ghrc_pkg::KindNoFree)
    else $error("bad result kind");
endmodule

bind guest_host_register_cache ghrc_checker u_ghrc_checker (
  .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall, .out_data_o, .cfg_ready
);

### bench/ghrc_checker.sv
// Checker: watches the register cache channels, predicts each result and compares it.
`timescale 1ns / 1ps
module tb_ghrc_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  ghrc_pkg::req_t             in_data_i,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  ghrc_pkg::rsp_t             out_data_o,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [ghrc_pkg::MaskW-1:0] cfg_data_i,
  output int                         fail_count,
  output int                         pending_count,
  output int                         result_count
);

  localparam int NGuest = 32;
  localparam int NHost = 16;

  logic [ghrc_pkg::MaskW-1:0] mask_q;
  logic             g_map[NGuest];
  logic             g_dirty[NGuest];
  logic [3:0]       g_host[NGuest];
  logic [2:0]       h_kind[NHost];
  logic             h_map[NHost];
  logic [4:0]       h_guest[NHost];
  logic             h_branch[NHost];
  logic             h_lock[NHost];
  logic [3:0]       free_list[NHost];
  int               free_cnt;
  int               cur;
  ghrc_pkg::rsp_t   cmd_queue[$];

  function automatic ghrc_pkg::rsp_t mk(logic [2:0] k, logic [3:0] h, logic [4:0] g,
                                        logic l);
    ghrc_pkg::rsp_t r;
    r.kind = k;
    r.host_index = h;
    r.guest_index = g;
    r.last = l;
    return r;
  endfunction

  task automatic rebuild_tables();
    for (int i = 0; i < NGuest; i++) begin
      g_map[i] = 0;
      g_dirty[i] = 0;
      g_host[i] = 0;
    end
    free_cnt = 0;
    for (int i = 0; i < NHost; i++) begin
      h_kind[i] = mask_q[i] ? ghrc_pkg::TypeReserved : ghrc_pkg::TypeEmpty;
      h_map[i] = 0;
      h_guest[i] = 0;
      h_branch[i] = 0;
      h_lock[i] = 0;
      if (!mask_q[i]) begin
        free_list[free_cnt] = i[3:0];
        free_cnt++;
      end
    end
    cur = 0;
  endtask

  task automatic unmap_guest(logic [4:0] g);
    g_dirty[g] = 0;
    g_map[g] = 0;
    g_host[g] = 0;
  endtask

  task automatic reclaim_hosts(output bit found);
    logic [3:0] h;
    logic [4:0] m;
    found = 0;
    for (int i = 0; i < free_cnt; i++) begin
      h = free_list[i];
      if (h_lock[h]) continue;
      if (h_map[h]) begin
        m = h_guest[h];
        if (g_map[m] && g_host[m] == h) begin
          if (m != 0 && g_dirty[m])
            cmd_queue.push_back(mk(ghrc_pkg::KindSpill, h, m, 1'b0));
          unmap_guest(m);
        end
      end
      h_map[h] = 0;
      h_guest[h] = 0;
      h_kind[h] = ghrc_pkg::TypeEmpty;
      h_lock[h] = 0;
      if (!found) begin
        cur = i;
        found = 1;
      end
    end
  endtask

  task automatic predict_map(logic [4:0] g, logic [1:0] act, logic [2:0] typ);
    logic [3:0] h;
    bit found;
    if (g_map[g]) begin
      h = g_host[g];
      if (act != ghrc_pkg::ActBranch) begin
        h_lock[h] = 1;
        cmd_queue.push_back(mk(ghrc_pkg::KindHost, h, g, 1'b1));
        return;
      end
      if (g != 0 && g_dirty[g]) cmd_queue.push_back(mk(ghrc_pkg::KindSpill, h, g, 1'b0));
      unmap_guest(g);
      h_kind[h] = typ;
      h_map[h] = 0;
      h_guest[h] = 0;
      h_lock[h] = 1;
      h_branch[h] = 1;
      cmd_queue.push_back(mk(ghrc_pkg::KindHost, h, g, 1'b1));
      return;
    end
    while (cur < free_cnt && h_kind[free_list[cur]] != ghrc_pkg::TypeEmpty) cur++;
    if (cur >= free_cnt) begin
      reclaim_hosts(found);
      if (!found) begin
        cmd_queue.push_back(mk(ghrc_pkg::KindNoFree, 4'd0, g, 1'b1));
        return;
      end
    end
    h = free_list[cur];
    h_kind[h] = typ;
    h_lock[h] = 1;
    g_dirty[g] = 0;
    if (act != ghrc_pkg::ActBranch) begin
      h_map[h] = 1;
      h_guest[h] = g;
      g_map[g] = 1;
      g_host[g] = h;
    end else begin
      h_map[h] = 0;
      h_guest[h] = 0;
      h_branch[h] = 1;
    end
    if (act == ghrc_pkg::ActLoad || act == ghrc_pkg::ActBranch)
      cmd_queue.push_back(mk(g != 0 ? ghrc_pkg::KindLoad : ghrc_pkg::KindZero, h, g, 1'b0));
    cur++;
    cmd_queue.push_back(mk(ghrc_pkg::KindHost, h, g, 1'b1));
  endtask

  task automatic predict_op(ghrc_pkg::req_t r);
    logic [4:0] g;
    logic [3:0] h;
    logic [1:0] act;
    g = r.guest_reg;
    act = (r.action == 2'd3) ? ghrc_pkg::ActPlain : r.action;
    case (r.operation)
      ghrc_pkg::OpMap: begin
        predict_map(g, act, r.host_type);
        return;
      end
      ghrc_pkg::OpMark: g_dirty[g] = 1;
      ghrc_pkg::OpUnlock: begin
        h_lock[r.host_reg] = 0;
        h_branch[r.host_reg] = 0;
      end
      ghrc_pkg::OpClearJump: begin
        for (int i = 0; i < NGuest; i++) begin
          if (!g_map[i]) continue;
          h = g_host[i];
          if (i != 0 && g_dirty[i])
            cmd_queue.push_back(mk(ghrc_pkg::KindSpill, h, 5'(i), 1'b0));
          unmap_guest(5'(i));
          h_map[h] = 0;
          h_guest[h] = 0;
          h_kind[h] = ghrc_pkg::TypeEmpty;
          h_lock[h] = 0;
        end
      end
      ghrc_pkg::OpClearBranch: begin
        for (int i = 1; i < NGuest; i++)
          if (g_map[i] && g_dirty[i])
            cmd_queue.push_back(mk(ghrc_pkg::KindSpill, g_host[i], 5'(i), 1'b0));
      end
      ghrc_pkg::OpReset: rebuild_tables();
      default: ;
    endcase
    cmd_queue.push_back(mk(ghrc_pkg::KindDone, 4'd0, 5'd0, 1'b1));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ghrc_pkg::rsp_t exp_r;
    if (!rst_ni) begin
      mask_q = ghrc_pkg::MaskReset;
      rebuild_tables();
      cmd_queue.delete();
      fail_count <= 0;
      result_count <= 0;
      pending_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        result_count <= result_count + 1;
        if (cmd_queue.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %p", $time, out_data_o);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = cmd_queue.pop_front();
          if (out_data_o !== exp_r) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_r, out_data_o);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) mask_q = cfg_data_i;
      if (in_valid && !in_stall) predict_op(in_data_i);
      pending_count <= cmd_queue.size();
    end
  end

endmodule

### bench/tb_guest_host_register_cache.sv
// Testbench top: drives the register cache with operations and mask writes, gives the verdict.
`timescale 1ns / 1ps
module tb_guest_host_register_cache;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid;
  logic                       in_stall;
  ghrc_pkg::req_t             in_data_i;
  logic                       out_valid;
  logic                       out_stall;
  ghrc_pkg::rsp_t             out_data_o;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [ghrc_pkg::MaskW-1:0] cfg_data_i;
  int                         fail_count;
  int                         pending_count;
  int                         result_count;
  int                         hold_cycles;
  bit                         hold_req;
  bit                         hold_taken;
  bit                         calm;
  int                         item_count;

  guest_host_register_cache dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid(in_valid), .in_stall(in_stall), .in_data_i(in_data_i),
    .out_valid(out_valid), .out_stall(out_stall), .out_data_o(out_data_o),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data_i(cfg_data_i)
  );

  tb_ghrc_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid(in_valid), .in_stall(in_stall), .in_data_i(in_data_i),
    .out_valid(out_valid), .out_stall(out_stall), .out_data_o(out_data_o),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data_i(cfg_data_i),
    .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
  );

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver: random stalls, a long hold-off on request, calm stretch on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_cycles <= 0;
      hold_taken <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      out_stall <= 1'b1;
      hold_cycles <= 300;
      hold_taken <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 20);
    end
  end

  task automatic send_op(logic [2:0] op, logic [4:0] g, logic [3:0] h,
                         logic [1:0] act, logic [2:0] typ);
    while (!calm && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data_i <= '{operation: op, guest_reg: g, host_reg: h, action: act, host_type: typ};
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    item_count++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_mask(logic [ghrc_pkg::MaskW-1:0] m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_op();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55)
      send_op(ghrc_pkg::OpMap, 5'($urandom_range(31)), 4'($urandom_range(15)),
              2'($urandom_range(3)), 3'($urandom_range(7)));
    else if (pick < 70)
      send_op(ghrc_pkg::OpMark, 5'($urandom_range(31)), 4'($urandom_range(15)),
              2'($urandom_range(3)), 3'($urandom_range(7)));
    else if (pick < 85)
      send_op(ghrc_pkg::OpUnlock, 5'($urandom_range(31)), 4'($urandom_range(15)),
              2'($urandom_range(3)), 3'($urandom_range(7)));
    else
      send_op(3'($urandom_range(7)), 5'($urandom_range(31)), 4'($urandom_range(15)),
              2'($urandom_range(3)), 3'($urandom_range(7)));
  endtask

  initial begin
    logic [ghrc_pkg::MaskW-1:0] masks[5];
    masks = '{16'h0000, 16'hFFFF, 16'hFFF0, 16'h5A5A, 16'($urandom_range(65535))};
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data_i = '0;
    cfg_valid = 1'b0;
    cfg_data_i = '0;
    hold_req = 0;
    calm = 0;
    item_count = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: default mask, every operation and action, special cases
    send_op(ghrc_pkg::OpMap, 5'd0, 4'd0, ghrc_pkg::ActLoad, 3'd2);
    send_op(ghrc_pkg::OpMap, 5'd31, 4'd15, ghrc_pkg::ActLoad, 3'd7);
    send_op(ghrc_pkg::OpMark, 5'd31, 4'd0, ghrc_pkg::ActPlain, 3'd0);
    send_op(ghrc_pkg::OpMark, 5'd0, 4'd0, ghrc_pkg::ActPlain, 3'd0);
    send_op(ghrc_pkg::OpMap, 5'd31, 4'd0, ghrc_pkg::ActPlain, 3'd3);
    send_op(ghrc_pkg::OpClearBranch, 5'd0, 4'd0, ghrc_pkg::ActPlain, 3'd0);
    send_op(ghrc_pkg::OpMap, 5'd31, 4'd0, ghrc_pkg::ActBranch, 3'd5);
    send_op(ghrc_pkg::OpMap, 5'd7, 4'd0, 2'd3, 3'd2);
    send_op(ghrc_pkg::OpMap, 5'd9, 4'd0, ghrc_pkg::ActBranch, 3'd4);
    send_op(ghrc_pkg::OpMap, 5'd10, 4'd0, ghrc_pkg::ActPlain, 3'd2);
    send_op(ghrc_pkg::OpMap, 5'd11, 4'd0, ghrc_pkg::ActPlain, 3'd2);
    send_op(ghrc_pkg::OpMap, 5'd12, 4'd0, ghrc_pkg::ActPlain, 3'd2);
    send_op(ghrc_pkg::OpMap, 5'd13, 4'd0, ghrc_pkg::ActPlain, 3'd2);
    send_op(ghrc_pkg::OpMap, 5'd14, 4'd0, ghrc_pkg::ActPlain, 3'd2);
    send_op(ghrc_pkg::OpUnlock, 5'd0, 4'd4, ghrc_pkg::ActPlain, 3'd0);
    send_op(ghrc_pkg::OpUnlock, 5'd0, 4'd15, ghrc_pkg::ActPlain, 3'd0);
    send_op(ghrc_pkg::OpMark, 5'd10, 4'd0, ghrc_pkg::ActPlain, 3'd0);
    send_op(ghrc_pkg::OpMap, 5'd15, 4'd0, ghrc_pkg::ActLoad, 3'd6);
    send_op(ghrc_pkg::OpMap, 5'd16, 4'd0, ghrc_pkg::ActLoad, 3'd6);
    send_op(3'd6, 5'd0, 4'd0, ghrc_pkg::ActPlain, 3'd0);
    send_op(3'd7, 5'd0, 4'd0, ghrc_pkg::ActPlain, 3'd0);
    send_op(ghrc_pkg::OpClearJump, 5'd0, 4'd0, ghrc_pkg::ActPlain, 3'd0);
    send_op(ghrc_pkg::OpReset, 5'd0, 4'd0, ghrc_pkg::ActPlain, 3'd0);

    // random phases across masks, each starting from a rebuilt free list
    for (int p = 0; p < 5; p++) begin
      write_mask(masks[p]);
      send_op(ghrc_pkg::OpReset, 5'd0, 4'd0, ghrc_pkg::ActPlain, 3'd0);
      calm = (p == 2);
      if (p == 1) hold_req = 1;
      for (int n = 0; n < 52; n++) send_random_op();
      calm = 0;
    end
    write_mask(ghrc_pkg::MaskReset);
    send_op(ghrc_pkg::OpReset, 5'd0, 4'd0, ghrc_pkg::ActPlain, 3'd0);
    for (int n = 0; n < 12; n++) send_random_op();

    in_valid <= 1'b0;
    drain();
    $display("Covered %0d operations with %0d results over six reserved-mask settings,",
             item_count, result_count);
    $display("including full spills, exhausted free lists and receiver hold-offs.");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
